/* rtl/voxel_boundary_step_assert.svh */
// Assertion macros shared by the voxel boundary step RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef VOXEL_BOUNDARY_STEP_ASSERT_SVH
`define VOXEL_BOUNDARY_STEP_ASSERT_SVH

// same-cycle implication
`define VBS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vbs assertion failed");

// next-cycle implication
`define VBS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vbs assertion failed");

`endif

/* rtl/vbs_pkg.sv */
// Types and constants of the voxel boundary step block.
// No dependencies; the front end, queue, divider, engine and top level import it.
`timescale 1ns / 1ps
`default_nettype none

package vbs_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int LimW     = 43;  // (points - 1) * spacing
  localparam int PtW      = 50;  // advanced point before range check
  localparam int TW       = 47;  // distance along the ray, Q31.16
  localparam int EmW      = 49;  // epsilon * 2 * spacing
  localparam int DivNW    = 48;
  localparam int DivDW    = 33;
  localparam int DivQW    = 47;
  localparam int DivIterW = 6;
  localparam int DivShW   = 64;
  localparam int QDepth   = 2;

  localparam logic [CfgIdxW-1:0] CFG_ORIGIN_X  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ORIGIN_Y  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ORIGIN_Z  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPACING_X = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SPACING_Y = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SPACING_Z = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_EPSILON   = 3'd6;

  typedef enum logic [1:0] {
    ST_MOVED       = 2'd0,
    ST_NOT_UNIT    = 2'd1,
    ST_LEFT_GRID   = 2'd2,
    ST_NUDGE_LIMIT = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
    logic [1:0]         status;
  } out_word_t;

  typedef struct packed {
    in_word_t w;
    logic     bad_dir;
  } job_t;

  typedef struct packed {
    logic [2:0][31:0] org;
    logic [2:0][30:0] sp;   // never zero
    logic [15:0]      eps;
  } cfg_t;

  typedef struct packed {
    logic                start;
    logic [DivNW-1:0]    num;
    logic [DivDW-1:0]    den;
    logic [DivIterW-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DivQW-1:0] quo;
    logic [DivNW-1:0] rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_REM_GO,
    S_REM_WAIT,
    S_CAND,
    S_DIV_WAIT,
    S_AXIS_NEXT,
    S_ADV_MUL,
    S_ADV_ADD,
    S_CHK_PT,
    S_FACE,
    S_FIN
  } back_state_e;

endpackage

`default_nettype wire

/* rtl/vbs_chan_if.sv */
// Valid/ready channel carrying one word of type T.
// Depends on nothing; the payload type comes from vbs_pkg at instantiation.
`timescale 1ns / 1ps
`default_nettype none

interface vbs_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/vbs_front.sv */
// Front end: takes input words, squares the direction and flags non-unit ones.
// Depends on vbs_pkg and vbs_chan_if.
`timescale 1ns / 1ps
`default_nettype none

module vbs_front import vbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  vbs_chan_if.sink    in_i,
  input  logic [15:0] eps_i,
  output job_t        push_o,
  output logic        push_valid_o,
  input  logic        push_ready_i
);

  in_word_t    w_in;
  in_word_t    w_q;
  logic        st_valid_q;
  logic [30:0] sq_q [3];
  logic [31:0] sum;
  logic [31:0] diff;
  logic        bad;

  assign w_in       = in_i.data;
  assign in_i.ready = !st_valid_q || push_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      st_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      w_q      <= w_in;
      sq_q[0]  <= 31'(w_in.dir_x * w_in.dir_x);
      sq_q[1]  <= 31'(w_in.dir_y * w_in.dir_y);
      sq_q[2]  <= 31'(w_in.dir_z * w_in.dir_z);
    end
  end

  // |S - 1.0| against twice epsilon, both in Q4.28
  always_comb begin
    sum  = 32'(sq_q[0]) + 32'(sq_q[1]) + 32'(sq_q[2]);
    diff = (sum >= 32'h1000_0000) ? (sum - 32'h1000_0000) : (32'h1000_0000 - sum);
    bad  = diff > {3'b000, eps_i, 13'b0};
  end

  assign push_o       = '{w: w_q, bad_dir: bad};
  assign push_valid_o = st_valid_q;

endmodule

`default_nettype wire

/* rtl/vbs_queue.sv */
// Short job queue between the front end and the stepping engine.
// Depends on vbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vbs_queue import vbs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  job_t push_i,
  input  logic push_valid_i,
  output logic push_ready_o,
  output job_t pop_o,
  output logic pop_valid_o,
  input  logic pop_i
);

  localparam int PtrW = $clog2(QDepth);
  localparam int CntW = $clog2(QDepth + 1);

  job_t            mem_q [QDepth];
  logic [PtrW-1:0] wp_q;
  logic [PtrW-1:0] rp_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push;
  logic            do_pop;

  assign push_ready_o = cnt_q != CntW'(QDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_o        = mem_q[rp_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= (wp_q == PtrW'(QDepth - 1)) ? '0 : wp_q + 1'b1;
      end
      if (do_pop) begin
        rp_q <= (rp_q == PtrW'(QDepth - 1)) ? '0 : rp_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= push_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/vbs_divider.sv */
// Shared serial divider, one quotient bit per cycle, for cell remainders
// and face distances. Depends on vbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vbs_divider import vbs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DivNW-1:0]    r_q;
  logic [DivShW-1:0]   d_q;
  logic [DivQW-1:0]    q_q;
  logic [DivIterW-1:0] k_q;
  logic                busy_q;
  logic                done_q;
  logic                ge;

  assign ge = {{(DivShW - DivNW){1'b0}}, r_q} >= d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      k_q    <= req_i.iters;
    end else if (busy_q) begin
      k_q <= k_q - 1'b1;
      if (k_q == DivIterW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // divisor starts aligned to the top quotient bit and walks down
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      r_q <= req_i.num;
      d_q <= DivShW'(req_i.den) << (req_i.iters - 1'b1);
      q_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        r_q <= r_q - d_q[DivNW-1:0];
      end
      q_q <= {q_q[DivQW-2:0], ge};
      d_q <= d_q >> 1;
    end
  end

  assign rsp_o = '{busy: busy_q, done: done_q, quo: q_q, rem: r_q};

endmodule

`default_nettype wire

/* rtl/vbs_back.sv */
// Stepping engine: finds the nearest face, advances, nudges off faces and
// registers the result word. Depends on vbs_pkg, vbs_chan_if and the assert macros.
`timescale 1ns / 1ps
`default_nettype none
`include "voxel_boundary_step_assert.svh"

module vbs_back import vbs_pkg::*; #(
  parameter int POINTS_X   = 256,
  parameter int POINTS_Y   = 256,
  parameter int POINTS_Z   = 256,
  parameter int MAX_NUDGES = 50
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  job_t       job_i,
  input  logic       job_valid_i,
  output logic       job_pop_o,
  output div_req_t   div_req_o,
  input  div_rsp_t   div_rsp_i,
  vbs_chan_if.source out_o
);

  localparam int MaxPtsXy = (POINTS_X > POINTS_Y) ? POINTS_X : POINTS_Y;
  localparam int MaxPts   = (MaxPtsXy > POINTS_Z) ? MaxPtsXy : POINTS_Z;
  localparam int ModIter  = $clog2(MaxPts);

  back_state_e        state_q, state_d;
  logic signed [31:0] pos_q [3];
  logic signed [15:0] dir_q [3];
  logic               bad_q;
  logic signed [PtW-1:0] pt_q [3];
  logic [TW-1:0]      t_q;
  logic [DivDW-1:0]   r_q;
  logic [7:0]         n_q;
  logic [1:0]         ax_q;
  logic               have_q;
  logic               face_ph_q;
  status_e            st_q;
  logic signed [63:0] prod_q;
  logic [LimW-1:0]    lim_q [3];
  logic [EmW-1:0]     em_q [3];
  logic               out_valid_q;
  out_word_t          out_q;

  logic [30:0]        sp_a;
  logic [DivDW-1:0]   m_a;
  logic [DivDW-1:0]   mr_a;
  logic signed [PtW:0] d_a;
  logic [DivNW-1:0]   w_a;
  logic [15:0]        ad_a;
  logic               dir_pos;
  logic               usable;
  logic               cand_ok;
  logic [DivDW-1:0]   num_a;
  logic               on_face;
  logic               inside_all;
  logic               q_better;
  logic               n_lt;
  logic               slot_free;
  status_e            fin_st;

  function automatic logic in_axis(input logic signed [PtW-1:0] p,
                                   input logic [31:0] o,
                                   input logic [LimW-1:0] lim);
    logic signed [PtW:0] v;
    logic                fits;
    v    = {p[PtW-1], p} - {{(PtW - 31){o[31]}}, o};
    fits = (p[PtW-1:31] == '0) || (p[PtW-1:31] == '1);
    return fits && !v[PtW] && (v[PtW-1:0] <= PtW'(lim));
  endfunction

  // per-axis limits, refreshed every cycle from the registers
  always_ff @(posedge clk_i) begin
    lim_q[0] <= LimW'(POINTS_X - 1) * LimW'(cfg_i.sp[0]);
    lim_q[1] <= LimW'(POINTS_Y - 1) * LimW'(cfg_i.sp[1]);
    lim_q[2] <= LimW'(POINTS_Z - 1) * LimW'(cfg_i.sp[2]);
    for (int i = 0; i < 3; i++) begin
      em_q[i] <= EmW'(cfg_i.eps) * EmW'({cfg_i.sp[i], 1'b0});
    end
  end

  always_comb begin
    sp_a    = cfg_i.sp[ax_q];
    m_a     = {1'b0, sp_a, 1'b0};
    mr_a    = m_a - r_q;
    d_a     = {pt_q[ax_q][PtW-1], pt_q[ax_q]}
              - {{(PtW - 31){cfg_i.org[ax_q][31]}}, cfg_i.org[ax_q]};
    // w = 2(p - origin) + spacing; p is inside so d is small and positive
    w_a     = {3'b000, d_a[43:0], 1'b0} + {17'b0, sp_a};
    ad_a    = dir_q[ax_q][15] ? 16'(-dir_q[ax_q]) : dir_q[ax_q];
    dir_pos = !dir_q[ax_q][15] && (dir_q[ax_q] != '0);
    usable  = {ad_a, 2'b00} > {2'b00, cfg_i.eps};
    cand_ok = usable && (dir_pos || (r_q != '0));
    num_a   = dir_pos ? mr_a : r_q;
    on_face = ({r_q, 16'b0} < em_q[ax_q]) || ({mr_a, 16'b0} < em_q[ax_q]);
    inside_all = in_axis(pt_q[0], cfg_i.org[0], lim_q[0])
              && in_axis(pt_q[1], cfg_i.org[1], lim_q[1])
              && in_axis(pt_q[2], cfg_i.org[2], lim_q[2]);
    q_better  = !have_q || (div_rsp_i.quo < t_q);
    n_lt      = n_q < 8'(MAX_NUDGES);
    slot_free = !out_valid_q || out_o.ready;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:      if (job_valid_i) state_d = S_CHECK;
      S_CHECK:     state_d = (bad_q || !inside_all) ? S_FIN : S_REM_GO;
      S_REM_GO:    state_d = S_REM_WAIT;
      S_REM_WAIT:  if (div_rsp_i.done) state_d = face_ph_q ? S_FACE : S_CAND;
      S_CAND:      state_d = cand_ok ? S_DIV_WAIT : S_AXIS_NEXT;
      S_DIV_WAIT:  if (div_rsp_i.done) state_d = S_AXIS_NEXT;
      S_AXIS_NEXT: begin
        if (ax_q != 2'd2) state_d = S_REM_GO;
        else state_d = have_q ? S_ADV_MUL : S_FIN;
      end
      S_ADV_MUL:   state_d = S_ADV_ADD;
      S_ADV_ADD:   state_d = (ax_q == 2'd2) ? S_CHK_PT : S_ADV_MUL;
      S_CHK_PT:    state_d = inside_all ? S_REM_GO : S_FIN;
      S_FACE: begin
        if (on_face) state_d = n_lt ? S_ADV_MUL : S_FIN;
        else state_d = (ax_q == 2'd2) ? S_FIN : S_REM_GO;
      end
      S_FIN:       if (slot_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    job_pop_o = 1'b0;
    div_req_o = '{start: 1'b0, num: w_a, den: m_a, iters: DivIterW'(ModIter)};
    fin_st    = ST_LEFT_GRID;
    case (state_q)
      S_IDLE:   job_pop_o = job_valid_i;
      S_CHECK:  fin_st = bad_q ? ST_NOT_UNIT : ST_LEFT_GRID;
      S_REM_GO: div_req_o.start = 1'b1;
      S_CAND: begin
        div_req_o.start = cand_ok;
        div_req_o.num   = {2'b00, num_a, 13'b0};
        div_req_o.den   = {17'b0, ad_a};
        div_req_o.iters = DivIterW'(DivQW);
      end
      S_FACE: begin
        if (on_face || !n_lt) fin_st = ST_NUDGE_LIMIT;
        else fin_st = ST_MOVED;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          pos_q[0] <= job_i.w.pos_x;
          pos_q[1] <= job_i.w.pos_y;
          pos_q[2] <= job_i.w.pos_z;
          dir_q[0] <= job_i.w.dir_x;
          dir_q[1] <= job_i.w.dir_y;
          dir_q[2] <= job_i.w.dir_z;
          pt_q[0]  <= PtW'(job_i.w.pos_x);
          pt_q[1]  <= PtW'(job_i.w.pos_y);
          pt_q[2]  <= PtW'(job_i.w.pos_z);
          bad_q    <= job_i.bad_dir;
          n_q      <= '0;
        end
      end
      S_CHECK: begin
        st_q      <= fin_st;
        ax_q      <= '0;
        have_q    <= 1'b0;
        face_ph_q <= 1'b0;
      end
      S_REM_WAIT: if (div_rsp_i.done) r_q <= div_rsp_i.rem[DivDW-1:0];
      S_DIV_WAIT: begin
        if (div_rsp_i.done && q_better) begin
          t_q    <= div_rsp_i.quo;
          have_q <= 1'b1;
        end
      end
      S_AXIS_NEXT: begin
        ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 1'b1;
        st_q <= ST_LEFT_GRID;
      end
      S_ADV_MUL: prod_q <= dir_q[ax_q] * $signed({1'b0, t_q});
      S_ADV_ADD: begin
        // floor(dir * t / 2^14)
        pt_q[ax_q] <= PtW'(pos_q[ax_q]) + prod_q[63:14];
        ax_q       <= (ax_q == 2'd2) ? 2'd0 : ax_q + 1'b1;
      end
      S_CHK_PT: begin
        st_q      <= ST_LEFT_GRID;
        face_ph_q <= 1'b1;
        ax_q      <= '0;
      end
      S_FACE: begin
        st_q <= fin_st;
        if (on_face && n_lt) begin
          t_q  <= t_q + TW'(cfg_i.eps);
          n_q  <= n_q + 1'b1;
          ax_q <= '0;
        end else if (!on_face) begin
          ax_q <= ax_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_FIN && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FIN && slot_free) begin
      out_q.status <= st_q;
      if (st_q == ST_MOVED) begin
        out_q.new_x <= pt_q[0][31:0];
        out_q.new_y <= pt_q[1][31:0];
        out_q.new_z <= pt_q[2][31:0];
      end else begin
        out_q.new_x <= pos_q[0];
        out_q.new_y <= pos_q[1];
        out_q.new_z <= pos_q[2];
      end
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  `VBS_ASSERT_IMP(a_div_free, div_req_o.start, !div_rsp_i.busy)
  `VBS_ASSERT_NXT(a_pop_loads, job_pop_o, state_q == S_CHECK)
  `VBS_ASSERT_IMP(a_adv_has_t, state_q == S_ADV_MUL, have_q)
  `VBS_ASSERT_NXT(a_fin_fills, state_q == S_FIN && !out_valid_q, out_valid_q)

endmodule

`default_nettype wire

/* rtl/voxel_boundary_step.sv */
// Voxel boundary step, top level.
// Takes a position and a Q2.14 direction on in_i (valid/ready) and returns
// one word on out_o: the position just past the next voxel face, or the
// input position with a failure status (not unit, left grid, nudge limit).
// Grid registers are written through cfg_we_i/cfg_idx_i/cfg_data_i; the
// user must write them only while the block is idle; it is not enforced.
// Flow: the front end and queue register each word; the engine then loads
// and checks it, runs per axis the cell remainder (ModIter quotient steps,
// ModIter = clog2(max points)) and, for a usable direction, the face
// distance on the 47-step serial divider, then advances and range-checks,
// checks each axis for a face, and per nudge advances and checks again.
// One word is in the engine at a time, set by the shared serial divider.
// The front end keeps accepting into a two-entry queue while the engine
// works. A finished word waits in the output register while out_o stalls;
// the engine then holds its next result until that register frees.
// Reset clears all handshake state and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module voxel_boundary_step import vbs_pkg::*; #(
  parameter int POINTS_X   = 256,
  parameter int POINTS_Y   = 256,
  parameter int POINTS_Z   = 256,
  parameter int MAX_NUDGES = 50
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  vbs_chan_if.sink            in_i,
  vbs_chan_if.source          out_o
);

  logic [2:0][31:0] org_q;
  logic [2:0][30:0] sp_q;
  logic [15:0]      eps_q;
  cfg_t             cfg;
  job_t             push;
  logic             push_valid;
  logic             push_ready;
  job_t             job;
  logic             job_valid;
  logic             job_pop;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q <= '0;
      sp_q  <= {3{31'd65536}};
      eps_q <= 16'd66;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ORIGIN_X:  org_q[0] <= cfg_data_i;
        CFG_ORIGIN_Y:  org_q[1] <= cfg_data_i;
        CFG_ORIGIN_Z:  org_q[2] <= cfg_data_i;
        CFG_SPACING_X: sp_q[0]  <= cfg_data_i[30:0];
        CFG_SPACING_Y: sp_q[1]  <= cfg_data_i[30:0];
        CFG_SPACING_Z: sp_q[2]  <= cfg_data_i[30:0];
        CFG_EPSILON:   eps_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // a zero spacing acts as the smallest spacing, one LSB
  always_comb begin
    cfg.org = org_q;
    cfg.eps = eps_q;
    for (int i = 0; i < 3; i++) begin
      cfg.sp[i] = (sp_q[i] == '0) ? 31'd1 : sp_q[i];
    end
  end

  vbs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .eps_i        (eps_q),
    .push_o       (push),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  vbs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_o        (job),
    .pop_valid_o  (job_valid),
    .pop_i        (job_pop)
  );

  vbs_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  vbs_back #(
    .POINTS_X   (POINTS_X),
    .POINTS_Y   (POINTS_Y),
    .POINTS_Z   (POINTS_Z),
    .MAX_NUDGES (MAX_NUDGES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .job_i       (job),
    .job_valid_i (job_valid),
    .job_pop_o   (job_pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
